// ===== src/dissemination_barrier_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Dissemination barrier unit: assertion macros
// Shared concurrent assertion forms for the barrier unit.
// ---------------------------------------------------------------------------
`ifndef DISSEMINATION_BARRIER_UNIT_DEFINES_SVH
`define DISSEMINATION_BARRIER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DBU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dissemination barrier check failed");

// next-cycle implication, disabled during reset
`define DBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dissemination barrier check failed");

`endif

// ===== src/dbu_pkg.sv =====
// ---------------------------------------------------------------------------
// Dissemination barrier package
// Widths, limits, register codes and the structs shared by the barrier unit.
// ---------------------------------------------------------------------------
package dbu_pkg;

	localparam int MAX_THREADS = 16;
	localparam int MAX_ROUNDS  = 4;

	localparam int TID_W  = 4;
	localparam int RND_W  = 2;
	localparam int TCNT_W = 5;
	localparam int RCNT_W = 3;
	localparam int FLAG_W = 2 * MAX_ROUNDS;
	localparam int FIDX_W = $clog2(FLAG_W);
	localparam int CFG_W  = 5;

	localparam logic [TCNT_W-1:0] THREADS_MIN   = TCNT_W'(2);
	localparam logic [TCNT_W-1:0] THREADS_LIMIT = TCNT_W'(MAX_THREADS);
	localparam logic [RCNT_W-1:0] ROUNDS_MIN    = RCNT_W'(1);
	localparam logic [RCNT_W-1:0] ROUNDS_LIMIT  = RCNT_W'(MAX_ROUNDS);

	typedef enum logic {
		CFG_THREAD_COUNT = 1'b0,
		CFG_ROUND_COUNT  = 1'b1
	} cfg_reg_t;

	typedef logic [FLAG_W-1:0] flag_row_t;

	typedef struct packed {
		logic [RND_W-1:0] round;
		logic             parity;
		logic             sense;
		logic             signalled;
	} thread_state_t;

	typedef struct packed {
		logic              we_state;
		thread_state_t     state;
		logic              we_flag;
		logic [TID_W-1:0]  flag_tid;
		logic [FIDX_W-1:0] flag_idx;
		logic              flag_val;
	} store_update_t;

	typedef struct packed {
		logic [TID_W-1:0] thread_echo;
		logic [TID_W-1:0] partner_id;
		logic             sent_signal;
		logic             advanced_round;
		logic             passed_barrier;
		logic [RND_W-1:0] round_now;
		logic             parity_now;
	} step_result_t;

endpackage

// ===== src/dbu_store.sv =====
// ---------------------------------------------------------------------------
// Barrier state store
// Per-thread round, parity, sense and signalled bits plus one flag row per
// thread, read at the stepping thread and written at thread and partner.
// ---------------------------------------------------------------------------
module dbu_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  logic [dbu_pkg::TID_W-1:0]    rd_tid,
	input  dbu_pkg::store_update_t       upd,
	output dbu_pkg::thread_state_t       rd_state,
	output dbu_pkg::flag_row_t           rd_flags
);

	dbu_pkg::thread_state_t state_q [dbu_pkg::MAX_THREADS];
	dbu_pkg::flag_row_t     flags_q [dbu_pkg::MAX_THREADS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dbu_pkg::MAX_THREADS; i++) begin
				state_q[i] <= '{round: '0, parity: 1'b0, sense: 1'b1, signalled: 1'b0};
				flags_q[i] <= '0;
			end
		end else if (we) begin
			if (upd.we_flag) begin
				flags_q[upd.flag_tid][upd.flag_idx] <= upd.flag_val;
			end
			if (upd.we_state) begin
				state_q[rd_tid] <= upd.state;
			end
		end
	end

	assign rd_state = state_q[rd_tid];
	assign rd_flags = flags_q[rd_tid];

endmodule

// ===== src/dbu_step.sv =====
// ---------------------------------------------------------------------------
// Barrier step logic
// One thread step: partner select, flag send, own-flag check, round advance
// and barrier pass with sense reversal.
// ---------------------------------------------------------------------------
module dbu_step (
	input  logic [dbu_pkg::TID_W-1:0]  tid,
	input  logic [dbu_pkg::TCNT_W-1:0] thread_count,
	input  logic [dbu_pkg::RCNT_W-1:0] round_count,
	input  dbu_pkg::thread_state_t     cur,
	input  dbu_pkg::flag_row_t         own_row,
	output dbu_pkg::store_update_t     upd,
	output dbu_pkg::step_result_t      res
);

	always_comb begin
		logic [dbu_pkg::TCNT_W-1:0] n;
		logic [dbu_pkg::RCNT_W-1:0] nr;
		logic [dbu_pkg::RCNT_W-1:0] r_ext;
		logic [dbu_pkg::RCNT_W-1:0] r_next;
		logic [dbu_pkg::FIDX_W-1:0] fidx;
		logic [dbu_pkg::TCNT_W-1:0] sum;
		logic [dbu_pkg::TID_W-1:0]  partner;
		logic                       sig;
		logic                       sent;
		logic                       adv;
		logic                       passed;
		logic                       own;

		if (thread_count < dbu_pkg::THREADS_MIN) n = dbu_pkg::THREADS_MIN;
		else if (thread_count > dbu_pkg::THREADS_LIMIT) n = dbu_pkg::THREADS_LIMIT;
		else n = thread_count;

		if (round_count < dbu_pkg::ROUNDS_MIN) nr = dbu_pkg::ROUNDS_MIN;
		else if (round_count > dbu_pkg::ROUNDS_LIMIT) nr = dbu_pkg::ROUNDS_LIMIT;
		else nr = round_count;

		r_ext   = {1'b0, cur.round};
		r_next  = r_ext;
		fidx    = {cur.parity, cur.round};
		sum     = '0;
		partner = '0;
		sig     = cur.signalled;
		sent    = 1'b0;
		adv     = 1'b0;
		passed  = 1'b0;
		own     = 1'b0;

		upd          = '0;
		upd.state    = cur;
		upd.flag_idx = fidx;
		upd.flag_val = cur.sense;

		if ({1'b0, tid} < n) begin
			upd.we_state = 1'b1;
			if (r_ext >= nr) begin
				passed = 1'b1;
			end else begin
				sum = {1'b0, tid} + (dbu_pkg::TCNT_W'(1) << cur.round);
				if (sum >= n) sum = sum - n;
				partner = sum[dbu_pkg::TID_W-1:0];
				if (!cur.signalled) begin
					upd.we_flag  = 1'b1;
					upd.flag_tid = partner;
					sig          = 1'b1;
					sent         = 1'b1;
				end
				own = (sent && partner == tid) ? cur.sense : own_row[fidx];
				if (own == cur.sense) begin
					adv    = 1'b1;
					sig    = 1'b0;
					r_next = r_ext + dbu_pkg::RCNT_W'(1);
					if (r_next >= nr) passed = 1'b1;
				end
			end
			upd.state.signalled = sig;
			upd.state.round     = r_next[dbu_pkg::RND_W-1:0];
			if (passed) begin
				upd.state.round     = '0;
				upd.state.signalled = 1'b0;
				upd.state.parity    = ~cur.parity;
				if (cur.parity) upd.state.sense = ~cur.sense;
			end
		end

		res.thread_echo    = tid;
		res.partner_id     = partner;
		res.sent_signal    = sent;
		res.advanced_round = adv;
		res.passed_barrier = passed;
		res.round_now      = upd.state.round;
		res.parity_now     = upd.state.parity;
	end

endmodule

// ===== src/dissemination_barrier_unit.sv =====
// A beat passes the input stage, then the result register. Throughput: one thread
// step per cycle unless result_stall holds the result; per-thread state and flag rows
// are flip-flops read and written in one step stage, so steps run back to back.
// Reset (arst_n low): flags, rounds, parities and signalled bits clear, every
// sense goes to 1, thread_count returns to 16 and round_count to 4.
// ---------------------------------------------------------------------------
// Dissemination barrier unit
// Sense-reversing dissemination barrier, one thread step per beat.
// ---------------------------------------------------------------------------
`include "dissemination_barrier_unit_defines.svh"

module dissemination_barrier_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [dbu_pkg::CFG_W-1:0]    cfg_data,
	// step beats
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [dbu_pkg::TID_W-1:0]    thread_id,
	// result beats
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [dbu_pkg::TID_W-1:0]    thread_echo,
	output logic [dbu_pkg::TID_W-1:0]    partner_id,
	output logic                         sent_signal,
	output logic                         advanced_round,
	output logic                         passed_barrier,
	output logic [dbu_pkg::RND_W-1:0]    round_now,
	output logic                         parity_now
);

	logic [dbu_pkg::TCNT_W-1:0] thread_count_q;
	logic [dbu_pkg::RCNT_W-1:0] round_count_q;
	logic                       item_valid_s1;
	logic [dbu_pkg::TID_W-1:0]  thread_id_s1;
	logic                       result_valid_q;
	dbu_pkg::step_result_t      result_q;
	logic                       advance;
	dbu_pkg::thread_state_t     cur_state;
	dbu_pkg::flag_row_t         own_row;
	dbu_pkg::store_update_t     upd;
	dbu_pkg::step_result_t      res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thread_count_q <= dbu_pkg::THREADS_LIMIT;
			round_count_q  <= dbu_pkg::ROUNDS_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dbu_pkg::cfg_reg_t'(cfg_index))
				dbu_pkg::CFG_THREAD_COUNT: thread_count_q <= cfg_data[dbu_pkg::TCNT_W-1:0];
				dbu_pkg::CFG_ROUND_COUNT:  round_count_q  <= cfg_data[dbu_pkg::RCNT_W-1:0];
			endcase
		end
	end

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = item_valid_s1 && !advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			thread_id_s1 <= thread_id;
		end
	end

	dbu_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (item_valid_s1 && advance),
		.rd_tid   (thread_id_s1),
		.upd      (upd),
		.rd_state (cur_state),
		.rd_flags (own_row)
	);

	dbu_step u_step (
		.tid          (thread_id_s1),
		.thread_count (thread_count_q),
		.round_count  (round_count_q),
		.cur          (cur_state),
		.own_row      (own_row),
		.upd          (upd),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1) begin
			result_q <= res;
		end
	end

	assign result_valid   = result_valid_q;
	assign thread_echo    = result_q.thread_echo;
	assign partner_id     = result_q.partner_id;
	assign sent_signal    = result_q.sent_signal;
	assign advanced_round = result_q.advanced_round;
	assign passed_barrier = result_q.passed_barrier;
	assign round_now      = result_q.round_now;
	assign parity_now     = result_q.parity_now;

	`DBU_ASSERT_SAME(a_pass_resets_round, clk, arst_n, result_valid_q && result_q.passed_barrier, result_q.round_now == '0)
	`DBU_ASSERT_SAME(a_stale_pass_silent, clk, arst_n, result_valid_q && result_q.passed_barrier && !result_q.advanced_round, !result_q.sent_signal && result_q.partner_id == '0)
	`DBU_ASSERT_SAME(a_advance_moves_round, clk, arst_n, result_valid_q && result_q.advanced_round && !result_q.passed_barrier, result_q.round_now != '0)

endmodule
